// File: hdl/rnc_m2_pkg.sv
// shared constants and helpers for the method-2 packed stream decoder
// decode phase codes, result kinds, status codes and the crc-16 byte update
// no dependencies
package rnc_m2_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int DIST_W            = 13;
    localparam int LEN_W             = 9;
    localparam int PH_W              = 5;

    localparam logic [PH_W-1:0] PH_LOCK     = 5'd0;
    localparam logic [PH_W-1:0] PH_KEY      = 5'd1;
    localparam logic [PH_W-1:0] PH_CHECK    = 5'd2;
    localparam logic [PH_W-1:0] PH_TOP      = 5'd3;
    localparam logic [PH_W-1:0] PH_LIT      = 5'd4;
    localparam logic [PH_W-1:0] PH_B2       = 5'd5;
    localparam logic [PH_W-1:0] PH_B3       = 5'd6;
    localparam logic [PH_W-1:0] PH_B4       = 5'd7;
    localparam logic [PH_W-1:0] PH_LONGLEN  = 5'd8;
    localparam logic [PH_W-1:0] PH_ENDBIT   = 5'd9;
    localparam logic [PH_W-1:0] PH_SHORTOFF = 5'd10;
    localparam logic [PH_W-1:0] PH_MC1      = 5'd11;
    localparam logic [PH_W-1:0] PH_MC2      = 5'd12;
    localparam logic [PH_W-1:0] PH_MC3      = 5'd13;
    localparam logic [PH_W-1:0] PH_RL0      = 5'd14;
    localparam logic [PH_W-1:0] PH_RL1      = 5'd15;
    localparam logic [PH_W-1:0] PH_RL2      = 5'd16;
    localparam logic [PH_W-1:0] PH_RL3      = 5'd17;
    localparam logic [PH_W-1:0] PH_RUN      = 5'd18;
    localparam logic [PH_W-1:0] PH_OFF0     = 5'd19;
    localparam logic [PH_W-1:0] PH_OFF1     = 5'd20;
    localparam logic [PH_W-1:0] PH_OFF2     = 5'd21;
    localparam logic [PH_W-1:0] PH_OFF3     = 5'd22;
    localparam logic [PH_W-1:0] PH_OFF4     = 5'd23;
    localparam logic [PH_W-1:0] PH_OFF5     = 5'd24;
    localparam logic [PH_W-1:0] PH_OFF23    = 5'd25;
    localparam logic [PH_W-1:0] PH_OFFLOW   = 5'd26;
    localparam logic [PH_W-1:0] PH_COPY     = 5'd27;
    localparam logic [PH_W-1:0] PH_DONE     = 5'd28;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_WAIT   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LOCK    = 3'd1;
    localparam logic [2:0] ST_NOKEY   = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_KEY  = 2'd1;
    localparam logic [1:0] REG_CRC  = 2'd2;

    // reflected polynomial 0xa001, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/rnc_method2_lz_decoder_top.sv
// method-2 packed stream body decoder: flag bits, keyed literals, history copies
// holds the history memory and the decode sequencer
// depends on rnc_m2_pkg
// timing: a byte word gives its result (if any) in the cycle right after acceptance;
// a tick steps one decode phase per cycle, so when its result is valid after acceptance
// is set by the flag-bit phases walked; a history copy adds a memory read wait state
// throughput: one word at a time, next word accepted once the result is taken
// reset: asynchronous, clears control state; history contents stay undefined
module rnc_method2_lz_decoder_top #(
    parameter int HISTORY_DEPTH = rnc_m2_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  packed_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;

    logic [7:0] history [HISTORY_DEPTH];
    logic [7:0] rdata;

    logic [31:0] size_reg;
    logic [15:0] key_cfg_reg;
    logic [15:0] crc_cfg_reg;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  phase_reg, phase_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [15:0] rkey_reg, rkey_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [31:0] count_reg, count_next;
    logic [8:0]  len_reg, len_next;
    logic [12:0] dist_reg, dist_next;
    logic [2:0]  fstat_reg, fstat_next;

    logic        ovalid_reg, ovalid_next;
    logic [1:0]  okind_reg, okind_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic [2:0]  ostat_reg, ostat_next;

    logic          emit_en;
    logic [7:0]    emit_val;
    logic [AW-1:0] raddr;

    logic       bit_avail;
    logic [7:0] bit_src;
    logic       cur_bit;
    logic [8:0] len_dec;
    logic [15:0] rkey_rot;

    assign in_ready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign kind      = okind_reg;
    assign out_byte  = obyte_reg;
    assign status    = ostat_reg;

    assign bit_avail = (bits_reg != 4'd0) || held_valid_reg;
    assign bit_src   = (bits_reg == 4'd0) ? held_reg : shift_reg;
    assign cur_bit   = bit_src[7];
    assign len_dec   = len_reg - 9'd1;
    assign rkey_rot  = {rkey_reg[0], rkey_reg[15:1]};
    assign raddr     = wp_reg - AW'(dist_reg);

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            history[wp_reg] <= emit_val;
        end
        rdata <= history[raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        wp_next         = wp_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        rkey_next       = rkey_reg;
        rcrc_next       = rcrc_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        dist_next       = dist_reg;
        fstat_next      = fstat_reg;
        ovalid_next     = ovalid_reg && !out_ready;
        okind_next      = okind_reg;
        obyte_next      = obyte_reg;
        ostat_next      = ostat_reg;
        emit_en         = 1'b0;
        emit_val        = 8'h00;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (req_type)
                    begin
                        state_next = S_RUN;
                    end
                    else if (held_valid_reg || phase_reg == rnc_m2_pkg::PH_DONE)
                    begin
                        ovalid_next = 1'b1;
                        okind_next  = rnc_m2_pkg::KIND_REJECT;
                        obyte_next  = 8'h00;
                        ostat_next  = rnc_m2_pkg::ST_OK;
                    end
                    else
                    begin
                        held_next       = packed_byte;
                        held_valid_next = 1'b1;
                    end
                end
            end
            S_RDWAIT:
            begin
                len_next = len_dec;
                if (len_dec == 9'd0)
                begin
                    phase_next = rnc_m2_pkg::PH_TOP;
                end
                emit_en  = 1'b1;
                emit_val = rdata;
            end
            S_RUN:
            begin
                case (phase_reg)
                    rnc_m2_pkg::PH_DONE:
                    begin
                        ovalid_next = 1'b1;
                        okind_next  = rnc_m2_pkg::KIND_DONE;
                        obyte_next  = 8'h00;
                        ostat_next  = fstat_reg;
                        state_next  = S_IDLE;
                    end
                    rnc_m2_pkg::PH_CHECK:
                    begin
                        if (count_reg < size_reg)
                        begin
                            phase_next = rnc_m2_pkg::PH_TOP;
                        end
                        else
                        begin
                            if (count_reg > size_reg)
                                fstat_next = rnc_m2_pkg::ST_OVERRUN;
                            else if (rcrc_reg != crc_cfg_reg)
                                fstat_next = rnc_m2_pkg::ST_CRC;
                            else
                                fstat_next = rnc_m2_pkg::ST_OK;
                            phase_next = rnc_m2_pkg::PH_DONE;
                        end
                    end
                    rnc_m2_pkg::PH_COPY:
                    begin
                        if (len_reg == 9'd0)
                            phase_next = rnc_m2_pkg::PH_TOP;
                        else
                            state_next = S_RDWAIT;
                    end
                    rnc_m2_pkg::PH_LIT, rnc_m2_pkg::PH_LONGLEN, rnc_m2_pkg::PH_SHORTOFF,
                    rnc_m2_pkg::PH_RUN, rnc_m2_pkg::PH_OFFLOW:
                    begin
                        if (!held_valid_reg)
                        begin
                            ovalid_next = 1'b1;
                            okind_next  = rnc_m2_pkg::KIND_WAIT;
                            obyte_next  = 8'h00;
                            ostat_next  = rnc_m2_pkg::ST_OK;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            held_valid_next = 1'b0;
                            case (phase_reg)
                                rnc_m2_pkg::PH_LIT:
                                begin
                                    rkey_next  = rkey_rot;
                                    phase_next = rnc_m2_pkg::PH_TOP;
                                    emit_en    = 1'b1;
                                    emit_val   = held_reg ^ rkey_reg[7:0];
                                end
                                rnc_m2_pkg::PH_LONGLEN:
                                begin
                                    if (held_reg == 8'd0)
                                        phase_next = rnc_m2_pkg::PH_ENDBIT;
                                    else
                                    begin
                                        len_next   = {1'b0, held_reg} + 9'd8;
                                        phase_next = rnc_m2_pkg::PH_OFF0;
                                    end
                                end
                                rnc_m2_pkg::PH_SHORTOFF:
                                begin
                                    len_next   = 9'd2;
                                    dist_next  = {5'd0, held_reg} + 13'd1;
                                    phase_next = rnc_m2_pkg::PH_COPY;
                                end
                                rnc_m2_pkg::PH_RUN:
                                begin
                                    if (len_reg != 9'd0)
                                        len_next = len_dec;
                                    if (len_reg <= 9'd1)
                                    begin
                                        rkey_next  = rkey_rot;
                                        phase_next = rnc_m2_pkg::PH_TOP;
                                    end
                                    emit_en  = 1'b1;
                                    emit_val = held_reg ^ rkey_reg[7:0];
                                end
                                default:
                                begin
                                    dist_next  = {1'b0, dist_reg[3:0], held_reg} + 13'd1;
                                    phase_next = rnc_m2_pkg::PH_COPY;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        if (!bit_avail)
                        begin
                            ovalid_next = 1'b1;
                            okind_next  = rnc_m2_pkg::KIND_WAIT;
                            obyte_next  = 8'h00;
                            ostat_next  = rnc_m2_pkg::ST_OK;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            shift_next = {bit_src[6:0], 1'b0};
                            bits_next  = ((bits_reg == 4'd0) ? 4'd8 : bits_reg) - 4'd1;
                            if (bits_reg == 4'd0)
                                held_valid_next = 1'b0;
                            case (phase_reg)
                                rnc_m2_pkg::PH_LOCK:
                                begin
                                    if (cur_bit)
                                    begin
                                        fstat_next = rnc_m2_pkg::ST_LOCK;
                                        phase_next = rnc_m2_pkg::PH_DONE;
                                    end
                                    else
                                        phase_next = rnc_m2_pkg::PH_KEY;
                                end
                                rnc_m2_pkg::PH_KEY:
                                begin
                                    if (cur_bit && key_cfg_reg == 16'd0)
                                    begin
                                        fstat_next = rnc_m2_pkg::ST_NOKEY;
                                        phase_next = rnc_m2_pkg::PH_DONE;
                                    end
                                    else
                                    begin
                                        rkey_next  = key_cfg_reg;
                                        phase_next = rnc_m2_pkg::PH_CHECK;
                                    end
                                end
                                rnc_m2_pkg::PH_TOP:
                                    phase_next = cur_bit ? rnc_m2_pkg::PH_B2 : rnc_m2_pkg::PH_LIT;
                                rnc_m2_pkg::PH_B2:
                                    phase_next = cur_bit ? rnc_m2_pkg::PH_B3 : rnc_m2_pkg::PH_MC1;
                                rnc_m2_pkg::PH_B3:
                                    phase_next = cur_bit ? rnc_m2_pkg::PH_B4
                                                         : rnc_m2_pkg::PH_SHORTOFF;
                                rnc_m2_pkg::PH_B4:
                                begin
                                    if (cur_bit)
                                        phase_next = rnc_m2_pkg::PH_LONGLEN;
                                    else
                                    begin
                                        len_next   = 9'd3;
                                        phase_next = rnc_m2_pkg::PH_OFF0;
                                    end
                                end
                                rnc_m2_pkg::PH_ENDBIT:
                                    phase_next = rnc_m2_pkg::PH_CHECK;
                                rnc_m2_pkg::PH_MC1:
                                begin
                                    len_next   = {8'd0, cur_bit} + 9'd4;
                                    phase_next = rnc_m2_pkg::PH_MC2;
                                end
                                rnc_m2_pkg::PH_MC2:
                                    phase_next = cur_bit ? rnc_m2_pkg::PH_MC3 : rnc_m2_pkg::PH_OFF0;
                                rnc_m2_pkg::PH_MC3:
                                begin
                                    if ({len_dec[7:0], cur_bit} == 9'd9)
                                    begin
                                        len_next   = 9'd0;
                                        phase_next = rnc_m2_pkg::PH_RL0;
                                    end
                                    else
                                    begin
                                        len_next   = {len_dec[7:0], cur_bit};
                                        phase_next = rnc_m2_pkg::PH_OFF0;
                                    end
                                end
                                rnc_m2_pkg::PH_OFF0:
                                begin
                                    dist_next  = 13'd0;
                                    phase_next = cur_bit ? rnc_m2_pkg::PH_OFF1
                                                         : rnc_m2_pkg::PH_OFFLOW;
                                end
                                rnc_m2_pkg::PH_OFF1:
                                begin
                                    dist_next  = {12'd0, cur_bit};
                                    phase_next = rnc_m2_pkg::PH_OFF2;
                                end
                                rnc_m2_pkg::PH_OFF2:
                                begin
                                    if (cur_bit)
                                        phase_next = rnc_m2_pkg::PH_OFF3;
                                    else if (dist_reg != 13'd0)
                                        phase_next = rnc_m2_pkg::PH_OFFLOW;
                                    else
                                        phase_next = rnc_m2_pkg::PH_OFF23;
                                end
                                rnc_m2_pkg::PH_OFF3:
                                begin
                                    dist_next  = {dist_reg[11:0], cur_bit} | 13'd4;
                                    phase_next = rnc_m2_pkg::PH_OFF4;
                                end
                                rnc_m2_pkg::PH_OFF4:
                                    phase_next = cur_bit ? rnc_m2_pkg::PH_OFFLOW
                                                         : rnc_m2_pkg::PH_OFF5;
                                rnc_m2_pkg::PH_OFF5:
                                begin
                                    dist_next  = {dist_reg[11:0], cur_bit};
                                    phase_next = rnc_m2_pkg::PH_OFFLOW;
                                end
                                rnc_m2_pkg::PH_OFF23:
                                begin
                                    dist_next  = {12'd0, cur_bit} + 13'd2;
                                    phase_next = rnc_m2_pkg::PH_OFFLOW;
                                end
                                rnc_m2_pkg::PH_RL0, rnc_m2_pkg::PH_RL1, rnc_m2_pkg::PH_RL2:
                                begin
                                    len_next   = {5'd0, len_reg[2:0], cur_bit};
                                    phase_next = phase_reg + 5'd1;
                                end
                                rnc_m2_pkg::PH_RL3:
                                begin
                                    // run of (4-bit count * 4) + 12 literals
                                    len_next   = {3'd0, len_reg[2:0], cur_bit, 2'b00} + 9'd12;
                                    phase_next = rnc_m2_pkg::PH_RUN;
                                end
                                default:
                                    phase_next = rnc_m2_pkg::PH_TOP;
                            endcase
                        end
                    end
                endcase
            end
            default:
                state_next = S_IDLE;
        endcase

        if (emit_en)
        begin
            wp_next    = wp_reg + AW'(1);
            rcrc_next  = rnc_m2_pkg::crc16_byte(rcrc_reg, emit_val);
            if (count_reg != 32'hFFFF_FFFF)
                count_next = count_reg + 32'd1;
            ovalid_next = 1'b1;
            okind_next  = rnc_m2_pkg::KIND_BYTE;
            obyte_next  = emit_val;
            ostat_next  = rnc_m2_pkg::ST_OK;
            state_next  = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= 32'd0;
            key_cfg_reg    <= 16'd0;
            crc_cfg_reg    <= 16'd0;
            state_reg      <= S_IDLE;
            phase_reg      <= rnc_m2_pkg::PH_LOCK;
            wp_reg         <= '0;
            shift_reg      <= 8'd0;
            bits_reg       <= 4'd0;
            held_reg       <= 8'd0;
            held_valid_reg <= 1'b0;
            rkey_reg       <= 16'd0;
            rcrc_reg       <= 16'd0;
            count_reg      <= 32'd0;
            len_reg        <= 9'd0;
            dist_reg       <= 13'd0;
            fstat_reg      <= rnc_m2_pkg::ST_OK;
            ovalid_reg     <= 1'b0;
            okind_reg      <= rnc_m2_pkg::KIND_BYTE;
            obyte_reg      <= 8'd0;
            ostat_reg      <= rnc_m2_pkg::ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rnc_m2_pkg::REG_SIZE: size_reg    <= cfg_data;
                    rnc_m2_pkg::REG_KEY:  key_cfg_reg <= cfg_data[15:0];
                    rnc_m2_pkg::REG_CRC:  crc_cfg_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            wp_reg         <= wp_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            rkey_reg       <= rkey_next;
            rcrc_reg       <= rcrc_next;
            count_reg      <= count_next;
            len_reg        <= len_next;
            dist_reg       <= dist_next;
            fstat_reg      <= fstat_next;
            ovalid_reg     <= ovalid_next;
            okind_reg      <= okind_next;
            obyte_reg      <= obyte_next;
            ostat_reg      <= ostat_next;
        end
    end

    // memory read wait only follows a copy step
    a_rdwait_from_copy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDWAIT |-> $past(state_reg == S_RUN && phase_reg == rnc_m2_pkg::PH_COPY))
        else $error("read wait entered outside a copy step");

    // finished report only once decoding has ended
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && okind_reg == rnc_m2_pkg::KIND_DONE) |-> phase_reg == rnc_m2_pkg::PH_DONE)
        else $error("finished word while decoding still running");

    // held byte is only filled by an accepted byte word
    a_held_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_valid_reg) |-> $past(in_valid && in_ready && !req_type))
        else $error("held byte set without a byte word");

    // a decoded byte always advances the history pointer
    a_emit_wp: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |=> wp_reg == $past(wp_reg) + AW'(1))
        else $error("history pointer did not advance on a decoded byte");

endmodule
